@@ rtl/core/qrs_pkg.sv @@
// Package for the quadratic root solver: kinds, widths and the shared pipeline payload types.
// No dependencies.
package qrs_pkg;

   localparam int unsigned CoefW  = 16;
   localparam int unsigned DiscW  = 34;
   localparam int unsigned RadW   = 64;
   localparam int unsigned RootW  = 32;
   localparam int unsigned NumW   = 41;
   localparam int unsigned QuotW  = 42;
   localparam int unsigned ImagW  = 31;

   typedef enum logic [1:0] {
      KIND_TWO     = 2'd0,
      KIND_DOUBLE  = 2'd1,
      KIND_COMPLEX = 2'd2,
      KIND_INVALID = 2'd3
   } root_kind_type;

   // carried alongside the square root stages
   typedef struct packed {
      root_kind_type     kind;
      logic signed [CoefW-1:0] a;
      logic signed [CoefW-1:0] b;
   } side_type;

endpackage

@@ rtl/core/quadratic_root_solver.sv @@
// Top level of the quadratic root solver: discriminant, square root, divide, saturate.
// Depends on qrs_pkg, qrs_sqrt and qrs_div.
//
// Usage:
//   The req_ channel takes one transaction of signed Q8.8 coefficients a, b, c.
//   The rsp_ channel returns one transaction per request, in order: the root
//   kind, two Q16.16 roots (or the real part twice), the imaginary magnitude
//   and a saturation flag. a equal to zero gives kind invalid and zero fields.
//   The path holds 34 register stages: 2 discriminant stages (two 16x16
//   products, then the subtract and magnitude), 16 square root stages at two
//   root bits each, 1 numerator stage, 14 divide stages at three quotient bits
//   each, and 1 sign/saturate output register. Throughput is one transaction
//   per cycle when nothing stalls. A stall from the receiver on a waiting
//   result freezes every stage at once, so req_stall is rsp_stall while
//   rsp_valid is high; nothing is lost or repeated. Reset clears all
//   stage valid bits; payloads are not reset.
module quadratic_root_solver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [15:0]            req_coef_a,
   input  logic signed [15:0]            req_coef_b,
   input  logic signed [15:0]            req_coef_c,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_root_kind,
   output logic signed [31:0]            rsp_root_one,
   output logic signed [31:0]            rsp_root_two,
   output logic [30:0]                   rsp_imag_part,
   output logic                          rsp_saturated
);
   import qrs_pkg::*;

   logic stall;
   assign stall     = rsp_valid && rsp_stall;
   assign req_stall = stall;

   // stage 1: products
   logic                     s1_vld_ff;
   logic signed [31:0]       s1_bb_ff, s1_ac_ff;
   logic signed [CoefW-1:0]  s1_a_ff, s1_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (!stall) begin
         s1_vld_ff <= req_valid;
      end
      if (!stall) begin
         s1_bb_ff <= req_coef_b * req_coef_b;
         s1_ac_ff <= req_coef_a * req_coef_c;
         s1_a_ff  <= req_coef_a;
         s1_b_ff  <= req_coef_b;
      end
   end

   // stage 2: discriminant, kind, radicand
   logic signed [DiscW-1:0] d_in;
   logic [DiscW-1:0]        mag_in;
   root_kind_type           kind_in;
   logic                    s2_vld_ff;
   logic [RadW-1:0]         s2_rad_ff;
   side_type                s2_side_ff;

   always_comb begin
      d_in   = {{2{s1_bb_ff[31]}}, s1_bb_ff} - {s1_ac_ff, 2'b00};
      mag_in = d_in[DiscW-1] ? DiscW'(-d_in) : DiscW'(d_in);
      priority if (s1_a_ff == '0) begin
         kind_in = KIND_INVALID;
      end else if (d_in[DiscW-1]) begin
         kind_in = KIND_COMPLEX;
      end else if (d_in == '0) begin
         kind_in = KIND_DOUBLE;
      end else begin
         kind_in = KIND_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (!stall) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (!stall) begin
         s2_rad_ff  <= {mag_in, 30'd0};
         s2_side_ff <= '{kind: kind_in, a: s1_a_ff, b: s1_b_ff};
      end
   end

   logic      sq_vld;
   logic [31:0] sq_root;
   side_type  sq_side;

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .stall     (stall),
      .in_valid  (s2_vld_ff),
      .in_rad    (s2_rad_ff),
      .in_side   (s2_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // numerator stage: N = -B*2^15 +/- R (two real roots, else -B*2^15), split into magnitude and sign vs a
   logic signed [NumW-1:0] base_in, np_in, nm_in;
   logic                   a_neg_in;
   logic                   s3_vld_ff;
   root_kind_type          s3_kind_ff;
   logic [QuotW-1:0]       s3_n1_ff, s3_n2_ff, s3_ni_ff;
   logic                   s3_n1_neg_ff, s3_n2_neg_ff;
   logic [CoefW-1:0]       s3_dm_ff;
   logic signed [NumW-1:0] n1_sel, n2_sel;

   always_comb begin
      base_in  = -(NumW'(sq_side.b) <<< 15);
      np_in    = base_in + NumW'({1'b0, sq_root});
      nm_in    = base_in - NumW'({1'b0, sq_root});
      a_neg_in = sq_side.a[CoefW-1];
      if (sq_side.kind == KIND_TWO) begin
         n1_sel = np_in;
         n2_sel = nm_in;
      end else begin
         n1_sel = base_in;
         n2_sel = base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (!stall) begin
         s3_vld_ff <= sq_vld;
      end
      if (!stall) begin
         s3_kind_ff   <= sq_side.kind;
         s3_n1_ff     <= QuotW'(n1_sel[NumW-1] ? -n1_sel : n1_sel);
         s3_n2_ff     <= QuotW'(n2_sel[NumW-1] ? -n2_sel : n2_sel);
         s3_n1_neg_ff <= n1_sel[NumW-1] ^ a_neg_in;
         s3_n2_neg_ff <= n2_sel[NumW-1] ^ a_neg_in;
         s3_ni_ff     <= QuotW'(sq_root);
         s3_dm_ff     <= a_neg_in ? CoefW'(-sq_side.a) : sq_side.a;
      end
   end

   logic             dv_vld;
   root_kind_type    dv_kind;
   logic [QuotW-1:0] dv_q1, dv_q2, dv_qi;
   logic             dv_q1_neg, dv_q2_neg;

   qrs_div u_div (
      .clock      (clock),
      .reset      (reset),
      .stall      (stall),
      .in_valid   (s3_vld_ff),
      .in_kind    (s3_kind_ff),
      .in_n1      (s3_n1_ff),
      .in_n1_neg  (s3_n1_neg_ff),
      .in_n2      (s3_n2_ff),
      .in_n2_neg  (s3_n2_neg_ff),
      .in_ni      (s3_ni_ff),
      .in_dm      (s3_dm_ff),
      .out_valid  (dv_vld),
      .out_kind   (dv_kind),
      .out_q1     (dv_q1),
      .out_q1_neg (dv_q1_neg),
      .out_q2     (dv_q2),
      .out_q2_neg (dv_q2_neg),
      .out_qi     (dv_qi)
   );

   // output stage: sign restore and saturation
   logic [RootW-1:0] r1_in, r2_in;
   logic [ImagW-1:0] im_in;
   logic             sat1_in, sat2_in, sati_in;
   logic             o_vld_ff;
   logic [1:0]       o_kind_ff;
   logic [RootW-1:0] o_r1_ff, o_r2_ff;
   logic [ImagW-1:0] o_im_ff;
   logic             o_sat_ff;

   function automatic logic [RootW:0] sat_root(input logic [QuotW-1:0] m, input logic neg);
      logic [RootW:0] res;
      if (neg) begin
         if (m > QuotW'(33'h080000000)) res = {1'b1, 32'h80000000};
         else                           res = {1'b0, 32'(-m)};
      end else begin
         if (m > QuotW'(32'h7fffffff))  res = {1'b1, 32'h7fffffff};
         else                           res = {1'b0, m[RootW-1:0]};
      end
      return res;
   endfunction

   always_comb begin
      {sat1_in, r1_in} = sat_root(dv_q1, dv_q1_neg);
      {sat2_in, r2_in} = sat_root(dv_q2, dv_q2_neg);
      sati_in = (dv_qi > QuotW'(31'h7fffffff));
      im_in   = sati_in ? 31'h7fffffff : dv_qi[ImagW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (!stall) begin
         o_vld_ff <= dv_vld;
      end
      if (!stall) begin
         o_kind_ff <= dv_kind;
         unique case (dv_kind)
            KIND_INVALID: begin
               o_r1_ff <= '0; o_r2_ff <= '0; o_im_ff <= '0; o_sat_ff <= 1'b0;
            end
            KIND_COMPLEX: begin
               o_r1_ff <= r1_in; o_r2_ff <= r1_in; o_im_ff <= im_in;
               o_sat_ff <= sat1_in | sati_in;
            end
            KIND_DOUBLE: begin
               o_r1_ff <= r1_in; o_r2_ff <= r1_in; o_im_ff <= '0;
               o_sat_ff <= sat1_in;
            end
            default: begin
               o_r1_ff <= r1_in; o_r2_ff <= r2_in; o_im_ff <= '0;
               o_sat_ff <= sat1_in | sat2_in;
            end
         endcase
      end
   end

   assign rsp_valid     = o_vld_ff;
   assign rsp_root_kind = o_kind_ff;
   assign rsp_root_one  = o_r1_ff;
   assign rsp_root_two  = o_r2_ff;
   assign rsp_imag_part = o_im_ff;
   assign rsp_saturated = o_sat_ff;

   // invalid kind never carries results
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind == KIND_INVALID |->
         rsp_root_one == '0 && rsp_root_two == '0 && !rsp_saturated)
      else $error("invalid kind with nonzero result");
   // real kinds carry no imaginary part
   a_real_no_imag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_kind != KIND_COMPLEX |-> rsp_imag_part == '0)
      else $error("imaginary part on real roots");
   // a double or complex result reports the same value twice
   a_equal_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_kind == KIND_DOUBLE || rsp_root_kind == KIND_COMPLEX)
         |-> rsp_root_one == rsp_root_two)
      else $error("paired roots differ");
   // a held result stays valid, with root_one unchanged, while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_root_one))
      else $error("stalled result changed");

endmodule

@@ rtl/core/qrs_sqrt.sv @@
// Pipelined integer square root, two result bits per stage, stall aware.
// Depends on qrs_pkg for the side-band payload type.
module qrs_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      stall,
   input  logic                      in_valid,
   input  logic [qrs_pkg::RadW-1:0]  in_rad,
   input  qrs_pkg::side_type         in_side,
   output logic                      out_valid,
   output logic [31:0]               out_root,
   output qrs_pkg::side_type         out_side
);
   import qrs_pkg::*;

   localparam int unsigned Stages = 16;
   localparam int unsigned Steps  = 2;

   logic                   vld_ff  [Stages+1];
   logic [RadW-1:0]        rem_ff  [Stages+1];
   logic [31:0]            res_ff  [Stages+1];
   logic [RadW-1:0]        rad_ff  [Stages+1];
   side_type               side_ff [Stages+1];

   always_comb begin
      vld_ff[0]  = in_valid;
      rem_ff[0]  = '0;
      res_ff[0]  = '0;
      rad_ff[0]  = in_rad;
      side_ff[0] = in_side;
   end

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [RadW-1:0] rem_in;
      logic [31:0]     res_in;
      logic [RadW-1:0] rad_in;
      always_comb begin
         logic [RadW-1:0] rem;
         logic [31:0]     res;
         logic [RadW-1:0] rad;
         logic [RadW-1:0] trial;
         rem = rem_ff[s];
         res = res_ff[s];
         rad = rad_ff[s];
         for (int k = 0; k < Steps; k++) begin
            rem   = {rem[RadW-3:0], rad[RadW-1:RadW-2]};
            rad   = {rad[RadW-3:0], 2'b00};
            // 4*res + 1 is the partial root with the two bits 01 appended below it
            trial = {{(RadW-34){1'b0}}, res, 2'b01};
            if (rem >= trial) begin
               rem = rem - trial;
               res = {res[30:0], 1'b1};
            end else begin
               res = {res[30:0], 1'b0};
            end
         end
         rem_in = rem;
         res_in = res;
         rad_in = rad;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (!stall) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (!stall) begin
            rem_ff[s+1]  <= rem_in;
            res_ff[s+1]  <= res_in;
            rad_ff[s+1]  <= rad_in;
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[Stages];
   assign out_root  = res_ff[Stages];
   assign out_side  = side_ff[Stages];

endmodule

@@ rtl/core/qrs_div.sv @@
// Pipelined restoring divider, unsigned 42-bit dividend by 16-bit divisor, sign flags carried through.
// Depends on qrs_pkg for widths and kinds.
module qrs_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        stall,
   input  logic                        in_valid,
   input  qrs_pkg::root_kind_type      in_kind,
   input  logic [qrs_pkg::QuotW-1:0]   in_n1,
   input  logic                        in_n1_neg,
   input  logic [qrs_pkg::QuotW-1:0]   in_n2,
   input  logic                        in_n2_neg,
   input  logic [qrs_pkg::QuotW-1:0]   in_ni,
   input  logic [qrs_pkg::CoefW-1:0]   in_dm,
   output logic                        out_valid,
   output qrs_pkg::root_kind_type      out_kind,
   output logic [qrs_pkg::QuotW-1:0]   out_q1,
   output logic                        out_q1_neg,
   output logic [qrs_pkg::QuotW-1:0]   out_q2,
   output logic                        out_q2_neg,
   output logic [qrs_pkg::QuotW-1:0]   out_qi
);
   import qrs_pkg::*;

   localparam int unsigned Stages = 14;
   localparam int unsigned Steps  = 3;
   localparam int unsigned RemW   = CoefW + 1;

   typedef struct packed {
      logic [QuotW-1:0] q;
      logic [RemW-1:0]  r;
   } lane_type;

   logic                vld_ff [Stages+1];
   lane_type            l_ff   [3][Stages+1];
   logic [CoefW-1:0]    dm_ff  [Stages+1];
   root_kind_type       kind_ff[Stages+1];
   logic [1:0]          neg_ff [Stages+1];

   always_comb begin
      vld_ff[0]  = in_valid;
      l_ff[0][0] = '{q: in_n1, r: '0};
      l_ff[1][0] = '{q: in_n2, r: '0};
      l_ff[2][0] = '{q: in_ni, r: '0};
      dm_ff[0]   = in_dm;
      kind_ff[0] = in_kind;
      neg_ff[0]  = {in_n2_neg, in_n1_neg};
   end

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      lane_type l_in [3];
      always_comb begin
         lane_type        t;
         logic [RemW-1:0] sh;
         for (int j = 0; j < 3; j++) begin
            t = l_ff[j][s];
            for (int k = 0; k < Steps; k++) begin
               sh  = {t.r[RemW-2:0], t.q[QuotW-1]};
               t.q = {t.q[QuotW-2:0], 1'b0};
               if (sh >= {1'b0, dm_ff[s]}) begin
                  t.r = sh - {1'b0, dm_ff[s]};
                  t.q[0] = 1'b1;
               end else begin
                  t.r = sh;
               end
            end
            l_in[j] = t;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (!stall) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (!stall) begin
            l_ff[0][s+1] <= l_in[0];
            l_ff[1][s+1] <= l_in[1];
            l_ff[2][s+1] <= l_in[2];
            dm_ff[s+1]   <= dm_ff[s];
            kind_ff[s+1] <= kind_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
         end
      end
   end

   assign out_valid  = vld_ff[Stages];
   assign out_kind   = kind_ff[Stages];
   assign out_q1     = l_ff[0][Stages].q;
   assign out_q2     = l_ff[1][Stages].q;
   assign out_qi     = l_ff[2][Stages].q;
   assign out_q1_neg = neg_ff[Stages][0];
   assign out_q2_neg = neg_ff[Stages][1];

endmodule

@@ bench/quadratic_root_solver_test.sv @@
// Testbench for quadratic_root_solver: random and directed coefficient sets, in-order
// check of every root transaction against a built-in fixed-point predictor.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
`timescale 1ns / 1ps

import qrs_pkg::*;

typedef struct {
   root_kind_type    kind;
   logic signed [31:0] one;
   logic signed [31:0] two;
   logic [30:0]        imag;
   logic               sat;
} roots_type;

// Holds the roots predicted for accepted coefficient sets, oldest first.
class root_scoreboard;
   roots_type pending_roots[$];
   int        mismatches;

   // floor(sqrt(v)), bit by bit
   static function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bit_val;
      res = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val >>= 2;
      while (bit_val != 0) begin
         if (v >= res + bit_val) begin
            v -= res + bit_val;
            res = (res >> 1) + bit_val;
         end else begin
            res >>= 1;
         end
         bit_val >>= 2;
      end
      return res;
   endfunction

   static function automatic longint clip32(longint v, inout logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function void note_coefs(logic signed [15:0] ca, logic signed [15:0] cb,
                            logic signed [15:0] cc);
      longint a, b, c, disc, rad, base, am, im;
      longint unsigned mag;
      roots_type r;
      a = ca;
      b = cb;
      c = cc;
      r.one = 0;
      r.two = 0;
      r.imag = 0;
      r.sat = 1'b0;
      if (a == 0) begin
         r.kind = KIND_INVALID;
      end else begin
         disc = b * b - 4 * a * c;
         mag = (disc < 0) ? -disc : disc;
         rad = int_sqrt(mag << 30);
         base = -b * 32768;
         if (disc > 0) begin
            r.kind = KIND_TWO;
            r.one = clip32((base + rad) / a, r.sat);
            r.two = clip32((base - rad) / a, r.sat);
         end else if (disc == 0) begin
            r.kind = KIND_DOUBLE;
            r.one = clip32(base / a, r.sat);
            r.two = r.one;
         end else begin
            r.kind = KIND_COMPLEX;
            am = (a < 0) ? -a : a;
            r.one = clip32(base / a, r.sat);
            r.two = r.one;
            im = rad / am;
            if (im > 64'sd2147483647) begin
               im = 64'sd2147483647;
               r.sat = 1'b1;
            end
            r.imag = im[30:0];
         end
      end
      pending_roots.push_back(r);
   endfunction

   function void check_roots(logic [1:0] kind, logic signed [31:0] one,
                             logic signed [31:0] two, logic [30:0] imag, logic sat);
      roots_type e;
      if (pending_roots.size() == 0) begin
         $display("%0t: unexpected transaction kind %0d", $time, kind);
         mismatches++;
         return;
      end
      e = pending_roots.pop_front();
      if (kind !== e.kind) begin
         $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
         mismatches++;
      end
      if (one !== e.one) begin
         $display("%0t: root_one expected %0d actual %0d", $time, e.one, one);
         mismatches++;
      end
      if (two !== e.two) begin
         $display("%0t: root_two expected %0d actual %0d", $time, e.two, two);
         mismatches++;
      end
      if (imag !== e.imag) begin
         $display("%0t: imag_part expected %0d actual %0d", $time, e.imag, imag);
         mismatches++;
      end
      if (sat !== e.sat) begin
         $display("%0t: saturated expected %0d actual %0d", $time, e.sat, sat);
         mismatches++;
      end
   endfunction
endclass

module quadratic_root_solver_test;

   localparam int RandomSets   = 1500;
   localparam int WatchdogMax  = 20000;
   localparam int DrainCycles  = 60;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_coef_a;
   logic signed [15:0] req_coef_b;
   logic signed [15:0] req_coef_c;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_root_kind;
   logic signed [31:0] rsp_root_one;
   logic signed [31:0] rsp_root_two;
   logic [30:0]        rsp_imag_part;
   logic               rsp_saturated;

   root_scoreboard roots_board;
   bit  quiet_phase;    // long stretch with no idling on either side
   int  idle_cycles;

   quadratic_root_solver u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_coef_a    (req_coef_a),
      .req_coef_b    (req_coef_b),
      .req_coef_c    (req_coef_c),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_root_kind (rsp_root_kind),
      .rsp_root_one  (rsp_root_one),
      .rsp_root_two  (rsp_root_two),
      .rsp_imag_part (rsp_imag_part),
      .rsp_saturated (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Send one coefficient transaction; hold it until accepted.
   task automatic send_coefs(logic signed [15:0] ca, logic signed [15:0] cb,
                             logic signed [15:0] cc);
      while (!quiet_phase && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_coef_a <= ca;
      req_coef_b <= cb;
      req_coef_c <= cc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      roots_board.note_coefs(ca, cb, cc);
   endtask

   // Random coefficient: half the time small magnitudes so roots stay in range,
   // otherwise full range to hit saturation.
   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed(16'($urandom_range(511))) - 16'sd256;
         2: return $signed(16'($urandom_range(8191))) - 16'sd4096;
         default: return $signed(16'($urandom_range(65535)));
      endcase
   endfunction

   // Receiver: random stall, check on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            roots_board.check_roots(rsp_root_kind, rsp_root_one, rsp_root_two,
                                    rsp_imag_part, rsp_saturated);
         rsp_stall <= !quiet_phase && ($urandom_range(99) < 37);
      end
   end

   // Watchdog: cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogMax) begin
         $display("quadratic_root_solver_test NOT OK");
         $finish;
      end
   end

   initial begin
      logic signed [15:0] ra, rb, rc;
      int k;
      roots_board = new();
      quiet_phase = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_coef_a = '0;
      req_coef_b = '0;
      req_coef_c = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero a, double root, complex pair, extremes, saturation.
      send_coefs(16'sd0, 16'sd256, 16'sd256);          // invalid a
      send_coefs(16'sd0, -16'sd32768, 16'sd32767);     // invalid, wild b c
      send_coefs(16'sd256, -16'sd512, 16'sd256);       // (x-1)^2 double
      send_coefs(16'sd256, 16'sd0, -16'sd1024);        // x = +/-2
      send_coefs(16'sd256, 16'sd0, 16'sd256);          // x = +/-i
      send_coefs(16'sd256, 16'sd512, 16'sd1280);       // -1 +/- 2i
      send_coefs(16'sd1, -16'sd32768, 16'sd0);         // huge root, saturates
      send_coefs(16'sd1, 16'sd32767, 16'sd0);          // huge negative root
      send_coefs(16'sd1, 16'sd0, 16'sd32767);          // huge imaginary
      send_coefs(-16'sd1, 16'sd0, 16'sd32767);
      send_coefs(-16'sd32768, -16'sd32768, -16'sd32768);
      send_coefs(16'sd32767, 16'sd32767, 16'sd32767);
      send_coefs(-16'sd32768, 16'sd32767, 16'sd32767);
      send_coefs(16'sd32767, -16'sd32768, -16'sd32768);
      send_coefs(-16'sd256, 16'sd0, 16'sd0);           // D zero at root 0
      send_coefs(16'sd1, 16'sd0, 16'sd0);
      send_coefs(-16'sd1, -16'sd1, -16'sd1);
      send_coefs(16'sd3, 16'sd7, -16'sd5);             // irrational roots
      send_coefs(-16'sd32768, 16'sd0, 16'sd0);

      for (k = 0; k < RandomSets; k++) begin
         quiet_phase = (k >= 600 && k < 800);
         ra = pick_coef();
         rb = pick_coef();
         rc = pick_coef();
         // every so often force a perfect square so double roots occur
         if ($urandom_range(9) == 0) begin
            ra = $signed(16'($urandom_range(31))) - 16'sd16;
            rb = 16'sd2 * ra * ($signed(16'($urandom_range(15))) - 16'sd8);
            if (ra != 0) rc = (rb / 16'sd2) * (rb / 16'sd2) / ra;
         end
         send_coefs(ra, rb, rc);
      end
      req_valid <= 1'b0;

      while (roots_board.pending_roots.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (roots_board.mismatches == 0)
         $display("quadratic_root_solver_test OK");
      else
         $display("quadratic_root_solver_test NOT OK");
      $finish;
   end

endmodule
